### rtl/stu_pkg.sv
package stu_pkg;

  localparam int COORD_W = 32;
  localparam int SIZE_W = 13;
  localparam int PIX_W = 12;
  localparam int PIX_MAX_W = 16;
  localparam int DEPTH_W = 16;
  localparam int IDX_W = 4;
  localparam int NUM_COEF = 16;
  localparam int REG_ADDR_W = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  // register index codes, taken from paddr[2]
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] WIDTH_RESET = 13'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd1080;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

  typedef struct packed {
    logic                      kind;
    logic [IDX_W-1:0]          coef_index;
    logic signed [COORD_W-1:0] coef_value;
    logic [PIX_W-1:0]          pixel_x;
    logic [PIX_W-1:0]          pixel_y;
    logic [DEPTH_W-1:0]        depth_value;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] world_x;
    logic signed [COORD_W-1:0] world_y;
    logic signed [COORD_W-1:0] world_z;
    logic                      w_zero;
    logic                      clipped;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic                      kind;
    logic [IDX_W-1:0]          coef_index;
    logic signed [COORD_W-1:0] coef_value;
    logic signed [COORD_W-1:0] ndc_x;
    logic signed [COORD_W-1:0] ndc_y;
    logic signed [COORD_W-1:0] ndc_z;
  } ndc_item_t;

endpackage

### rtl/screen_to_world_unproject.sv
// throughput: one item per cycle, loads and points alike, while the queues do not fill up; set by the one-bit-per-stage
//   dividers (PIXEL_BITS+FRAC_BITS+1 stages in front, 31 stages in back)
// loads give no result; a point uses every coefficient loaded before it
// reset (rst, synchronous, high): queues and pipelines empty, size 1920x1080,
//   matrix back to identity
module screen_to_world_unproject #(
  parameter int PIXEL_BITS = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // item side
  input  logic                              push,
  output logic                              full,
  input  stu_pkg::in_item_t                 item,
  // result side
  output logic                              empty,
  input  logic                              pop,
  output stu_pkg::out_item_t                result,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stu_pkg::REG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [stu_pkg::SIZE_W-1:0] screen_width;
  logic [stu_pkg::SIZE_W-1:0] screen_height;
  logic                       reg_wr;

  logic                       mq_push;
  logic                       mq_full;
  logic                       mq_pop;
  logic                       mq_empty;
  stu_pkg::ndc_item_t         mq_wdata;
  logic [$bits(stu_pkg::ndc_item_t)-1:0] mq_rbits;
  stu_pkg::ndc_item_t         mq_rdata;

  logic                       of_push;
  logic                       of_full;
  stu_pkg::out_item_t         of_wdata;
  logic [$bits(stu_pkg::out_item_t)-1:0] of_rbits;

  // register port: zero wait states, register index in paddr[2]
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= stu_pkg::WIDTH_RESET;
      screen_height <= stu_pkg::HEIGHT_RESET;
    end else if (reg_wr) begin
      case (paddr[2])
        stu_pkg::REG_WIDTH:  screen_width  <= pwdata[stu_pkg::SIZE_W-1:0];
        stu_pkg::REG_HEIGHT: screen_height <= pwdata[stu_pkg::SIZE_W-1:0];
        default:             screen_width  <= screen_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      stu_pkg::REG_WIDTH:  prdata = {{(32-stu_pkg::SIZE_W){1'b0}}, screen_width};
      stu_pkg::REG_HEIGHT: prdata = {{(32-stu_pkg::SIZE_W){1'b0}}, screen_height};
      default:             prdata = '0;
    endcase
  end

  // front: pixel and depth to normalized device coordinates
  stu_front #(.PIXEL_BITS(PIXEL_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .screen_width(screen_width), .screen_height(screen_height),
    .mq_push(mq_push), .mq_item(mq_wdata), .mq_full(mq_full)
  );

  // short queue so front and back stall on their own
  stu_fifo #(.WIDTH($bits(stu_pkg::ndc_item_t)), .DEPTH(stu_pkg::QUEUE_DEPTH)) u_mid_q (
    .clk(clk), .rst(rst), .push(mq_push), .wdata(mq_wdata), .full(mq_full),
    .pop(mq_pop), .rdata(mq_rbits), .empty(mq_empty)
  );

  assign mq_rdata = stu_pkg::ndc_item_t'(mq_rbits);

  // back: coefficient loads, matrix product and perspective divide
  stu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .mq_empty(mq_empty), .mq_pop(mq_pop), .mq_item(mq_rdata),
    .of_push(of_push), .of_item(of_wdata), .of_full(of_full)
  );

  // result queue; its head drives the result ports
  stu_fifo #(.WIDTH($bits(stu_pkg::out_item_t)), .DEPTH(stu_pkg::QUEUE_DEPTH)) u_out_q (
    .clk(clk), .rst(rst), .push(of_push), .wdata(of_wdata), .full(of_full),
    .pop(pop && !empty), .rdata(of_rbits), .empty(empty)
  );

  assign result = stu_pkg::out_item_t'(of_rbits);

  a_wzero_clips: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.w_zero) |-> result.clipped)
    else $error("zero w without clipped flag");

endmodule

### rtl/stu_fifo.sv
module stu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue count out of range");

endmodule

### rtl/stu_div.sv
module stu_div #(
  parameter int BW = 13,
  parameter int QB = 29
) (
  input  logic          clk,
  input  logic          en,
  input  logic [BW-1:0] rem_in,
  input  logic [QB-1:0] bits_in,
  input  logic [BW-1:0] den_in,
  output logic [QB-1:0] quo
);

  // one quotient bit per stage; numerator bits shift out the top while
  // quotient bits shift in at the bottom of the same register
  logic [BW-1:0] rem_q [QB];
  logic [QB-1:0] num_q [QB];
  logic [BW-1:0] den_q [QB];

  logic [BW-1:0] rem_a [QB];
  logic [QB-1:0] num_a [QB];
  logic [BW-1:0] den_a [QB];
  logic [BW:0]   t_a   [QB];
  logic [BW:0]   dif_a [QB];
  logic          ge_a  [QB];

  always_comb begin
    rem_a[0] = rem_in;
    num_a[0] = bits_in;
    den_a[0] = den_in;
    for (int s = 1; s < QB; s++) begin
      rem_a[s] = rem_q[s-1];
      num_a[s] = num_q[s-1];
      den_a[s] = den_q[s-1];
    end
    for (int s = 0; s < QB; s++) begin
      t_a[s]   = {rem_a[s], num_a[s][QB-1]};
      ge_a[s]  = (t_a[s] >= {1'b0, den_a[s]});
      dif_a[s] = t_a[s] - {1'b0, den_a[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QB; s++) begin
        rem_q[s] <= ge_a[s] ? dif_a[s][BW-1:0] : t_a[s][BW-1:0];
        num_q[s] <= {num_a[s][QB-2:0], ge_a[s]};
        den_q[s] <= den_a[s];
      end
    end
  end

  assign quo = num_q[QB-1];

endmodule

### rtl/stu_front.sv
module stu_front #(
  parameter int PIXEL_BITS = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  stu_pkg::in_item_t           item,
  input  logic [stu_pkg::SIZE_W-1:0]  screen_width,
  input  logic [stu_pkg::SIZE_W-1:0]  screen_height,
  output logic                        mq_push,
  output stu_pkg::ndc_item_t          mq_item,
  input  logic                        mq_full
);

  localparam int QW = PIXEL_BITS + 1 + FRAC_BITS;
  localparam logic signed [63:0] ONE_W = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] MAX_W = 64'sh000000007fffffff;

  typedef struct packed {
    logic                               kind;
    logic [stu_pkg::IDX_W-1:0]          coef_index;
    logic signed [stu_pkg::COORD_W-1:0] coef_value;
    logic [stu_pkg::DEPTH_W-1:0]        depth_value;
  } side_t;

  logic                           adv;
  logic                           valid_in;
  side_t                          side_in;
  logic                           valid_q [1:QW];
  side_t                          side_q  [1:QW];
  logic [stu_pkg::PIX_MAX_W-1:0]  px_ext;
  logic [stu_pkg::PIX_MAX_W-1:0]  py_ext;
  logic [QW-1:0]                  num_x;
  logic [QW-1:0]                  num_y;
  logic [stu_pkg::SIZE_W-1:0]     den_x;
  logic [stu_pkg::SIZE_W-1:0]     den_y;
  logic [QW-1:0]                  qx;
  logic [QW-1:0]                  qy;
  logic signed [63:0]             dx;
  logic signed [63:0]             dy;
  logic [63:0]                    zs;

  assign full     = valid_q[QW] && mq_full;
  assign adv      = !full;
  assign valid_in = push && !full;
  assign side_in  = '{kind: item.kind, coef_index: item.coef_index,
                      coef_value: item.coef_value, depth_value: item.depth_value};

  // 2*pix << FRAC_BITS, only the low PIXEL_BITS of the pixel count
  assign px_ext = {{(stu_pkg::PIX_MAX_W-stu_pkg::PIX_W){1'b0}}, item.pixel_x};
  assign py_ext = {{(stu_pkg::PIX_MAX_W-stu_pkg::PIX_W){1'b0}}, item.pixel_y};
  assign num_x  = {px_ext[PIXEL_BITS-1:0], 1'b0, {FRAC_BITS{1'b0}}};
  assign num_y  = {py_ext[PIXEL_BITS-1:0], 1'b0, {FRAC_BITS{1'b0}}};
  // zero size behaves as one
  assign den_x  = (screen_width == '0) ? stu_pkg::SIZE_W'(1) : screen_width;
  assign den_y  = (screen_height == '0) ? stu_pkg::SIZE_W'(1) : screen_height;

  stu_div #(.BW(stu_pkg::SIZE_W), .QB(QW)) u_div_x (
    .clk(clk), .en(adv), .rem_in('0), .bits_in(num_x), .den_in(den_x), .quo(qx)
  );

  stu_div #(.BW(stu_pkg::SIZE_W), .QB(QW)) u_div_y (
    .clk(clk), .en(adv), .rem_in('0), .bits_in(num_y), .den_in(den_y), .quo(qy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= QW; s++) valid_q[s] <= 1'b0;
    end else if (adv) begin
      valid_q[1] <= valid_in;
      for (int s = 2; s <= QW; s++) valid_q[s] <= valid_q[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[1] <= side_in;
      for (int s = 2; s <= QW; s++) side_q[s] <= side_q[s-1];
    end
  end

  always_comb begin
    dx = $signed({{(64-QW){1'b0}}, qx}) - ONE_W;
    dy = $signed({{(64-QW){1'b0}}, qy}) - ONE_W;
    zs = ({{(64-stu_pkg::DEPTH_W){1'b0}}, side_q[QW].depth_value} << (FRAC_BITS + 1)) >> 16;
    mq_item.kind       = side_q[QW].kind;
    mq_item.coef_index = side_q[QW].coef_index;
    mq_item.coef_value = side_q[QW].coef_value;
    mq_item.ndc_x      = (dx > MAX_W) ? stu_pkg::COORD_MAX : dx[31:0];
    mq_item.ndc_y      = (dy > MAX_W) ? stu_pkg::COORD_MAX : dy[31:0];
    mq_item.ndc_z      = 32'($signed(zs) - ONE_W);
  end

  assign mq_push = adv && valid_q[QW];

endmodule

### rtl/stu_back.sv
module stu_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               mq_empty,
  output logic               mq_pop,
  input  stu_pkg::ndc_item_t mq_item,
  output logic               of_push,
  output stu_pkg::out_item_t of_item,
  input  logic               of_full
);

  localparam int HW = 66 - FRAC_BITS;   // width of a row sum
  localparam int NW = HW + FRAC_BITS;   // dividend width
  localparam int DQ = 31;               // quotient bits kept
  localparam int SH = 31 - FRAC_BITS;
  localparam int CW = HW + SH;

  typedef struct packed {
    logic       wz;
    logic [2:0] neg;
    logic [2:0] hn;
    logic [2:0] sat;
  } flags_t;

  logic signed [31:0] matrix [stu_pkg::NUM_COEF];
  logic signed [31:0] vvec   [4];
  logic signed [63:0] prod   [stu_pkg::NUM_COEF];
  logic signed [HW-1:0] h_c  [4];
  logic signed [HW-1:0] h    [4];
  logic [HW-1:0]      a_c    [3];
  logic [HW-1:0]      b_c;
  logic [NW-1:0]      n_c    [3];
  flags_t             fl_c;
  logic [HW-1:0]      rem3   [3];
  logic [DQ-1:0]      bits3  [3];
  logic [HW-1:0]      den3;
  flags_t             fl3;
  logic               v1;
  logic               v2;
  logic               v3;
  logic               vl     [1:DQ];
  flags_t             fl     [1:DQ];
  logic [DQ-1:0]      quo    [3];
  logic signed [31:0] res    [3];
  logic               adv;
  logic               take_pt;
  logic               take_ld;

  assign adv     = !(vl[DQ] && of_full);
  assign mq_pop  = adv && !mq_empty;
  assign take_pt = mq_pop && (mq_item.kind == stu_pkg::KIND_POINT);
  assign take_ld = mq_pop && (mq_item.kind == stu_pkg::KIND_LOAD);

  // coefficients are written in item order, so points already past the
  // product stage keep the old matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < stu_pkg::NUM_COEF; i++)
        matrix[i] <= (i % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
    end else if (take_ld) begin
      matrix[mq_item.coef_index] <= mq_item.coef_value;
    end
  end

  assign vvec[0] = mq_item.ndc_x;
  assign vvec[1] = mq_item.ndc_y;
  assign vvec[2] = mq_item.ndc_z;
  assign vvec[3] = 32'sd1 <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < stu_pkg::NUM_COEF; i++)
        prod[i] <= 64'(matrix[i]) * 64'(vvec[i % 4]);
    end
  end

  // floor shift of each product, exact row sums
  always_comb begin
    for (int r = 0; r < 4; r++)
      h_c[r] = HW'(prod[4*r] >>> FRAC_BITS) + HW'(prod[4*r+1] >>> FRAC_BITS)
             + HW'(prod[4*r+2] >>> FRAC_BITS) + HW'(prod[4*r+3] >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) h[r] <= h_c[r];
    end
  end

  // magnitudes, signs and the overflow test: quotient >= 2^31 when
  // |num| >= |w| << (31 - FRAC_BITS)
  always_comb begin
    b_c       = h[3][HW-1] ? HW'(-h[3]) : HW'(h[3]);
    fl_c.wz   = (h[3] == '0);
    for (int r = 0; r < 3; r++) begin
      a_c[r]        = h[r][HW-1] ? HW'(-h[r]) : HW'(h[r]);
      n_c[r]        = {a_c[r], {FRAC_BITS{1'b0}}};
      fl_c.hn[r]    = h[r][HW-1];
      fl_c.neg[r]   = h[r][HW-1] ^ h[3][HW-1];
      fl_c.sat[r]   = ({{SH{1'b0}}, a_c[r]} >= CW'({b_c, {SH{1'b0}}}));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        rem3[r]  <= HW'(n_c[r][NW-1:DQ]);
        bits3[r] <= n_c[r][DQ-1:0];
      end
      den3 <= b_c;
      fl3  <= fl_c;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_div
    stu_div #(.BW(HW), .QB(DQ)) u_div (
      .clk(clk), .en(adv), .rem_in(rem3[r]), .bits_in(bits3[r]),
      .den_in(den3), .quo(quo[r])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int s = 1; s <= DQ; s++) vl[s] <= 1'b0;
    end else if (adv) begin
      v1    <= take_pt;
      v2    <= v1;
      v3    <= v2;
      vl[1] <= v3;
      for (int s = 2; s <= DQ; s++) vl[s] <= vl[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fl[1] <= fl3;
      for (int s = 2; s <= DQ; s++) fl[s] <= fl[s-1];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (fl[DQ].wz)
        res[r] = fl[DQ].hn[r] ? stu_pkg::COORD_MIN : stu_pkg::COORD_MAX;
      else if (fl[DQ].sat[r])
        res[r] = fl[DQ].neg[r] ? stu_pkg::COORD_MIN : stu_pkg::COORD_MAX;
      else if (fl[DQ].neg[r])
        res[r] = 32'(-$signed({1'b0, quo[r]}));
      else
        res[r] = $signed({1'b0, quo[r]});
    end
    of_item.world_x = res[0];
    of_item.world_y = res[1];
    of_item.world_z = res[2];
    of_item.w_zero  = fl[DQ].wz;
    of_item.clipped = fl[DQ].wz || (fl[DQ].sat != 3'b000);
  end

  assign of_push = adv && vl[DQ];

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (take_ld && adv) |=> !v1)
    else $error("load item entered the point pipeline");

endmodule
